// File: hdl/load_cell_adc_reader_assert.svh
// assertion macros for the load cell reader checker
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LCAR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load cell reader check failed");

// next-cycle implication
`define LCAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load cell reader check failed");

`endif

// File: hdl/lcar_pkg.sv
// shared types, codes and helpers for the load cell reader
package lcar_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_HIGH,
        PH_WAIT_LOW,
        PH_CLK_HIGH,
        PH_CLK_LOW,
        PH_DELAY
    } phase_t;

    typedef enum logic [2:0] {
        C_RUN,
        C_AVG_START,
        C_AVG_WAIT,
        C_UNITS_START,
        C_UNITS_WAIT,
        C_OUT
    } ctrl_state_t;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_RAW   = 3'd1;
    localparam logic [2:0] OP_VALUE = 3'd2;
    localparam logic [2:0] OP_UNITS = 3'd3;
    localparam logic [2:0] OP_TARE  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TO_HIGH = 2'd1;
    localparam logic [1:0] ST_TO_LOW  = 2'd2;
    localparam logic [1:0] ST_DIV0    = 2'd3;

    localparam logic [0:0] REG_FAST  = 1'b0;
    localparam logic [0:0] REG_SCALE = 1'b1;

    localparam logic [9:0] WAIT_LIMIT_FAST = 10'd620;
    localparam logic [9:0] WAIT_LIMIT_SLOW = 10'd750;
    localparam logic [9:0] CAL_DELAY_FAST  = 10'd100;
    localparam logic [9:0] CAL_DELAY_SLOW  = 10'd800;
    localparam logic [9:0] READ_GAP        = 10'd1;

    localparam int DIV_W = 64;
    localparam int DVS_W = 32;

    typedef struct packed {
        logic in_ready;
        logic step_en;
        logic out_load_step;
        logic div_start;
        logic sel_units;
        logic avg_load;
        logic fin_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fin_ok;
        logic op_units;
        logic scale_zero;
    } eng_stat_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: hdl/lcar_if.sv
// step and result channels
interface lcar_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       calibrate;
    logic [7:0] sample_count;
    logic       dout;
    logic       ms_tick;

    modport source (output valid, operation, calibrate, sample_count, dout, ms_tick,
                    input ready);
    modport sink (input valid, operation, calibrate, sample_count, dout, ms_tick,
                  output ready);
endinterface

interface lcar_out_if;
    logic        valid;
    logic        ready;
    logic        sclk;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic signed [31:0] result;

    modport source (output valid, sclk, busy_res, done_res, status, result, input ready);
    modport sink (input valid, sclk, busy_res, done_res, status, result, output ready);
endinterface

// File: hdl/lcar_div.sv
// iterative signed-magnitude divider, one quotient bit per cycle
module lcar_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             neg,
    input  logic [lcar_pkg::DIV_W-1:0]       dividend,
    input  logic [lcar_pkg::DVS_W-1:0]       divisor,
    output logic                             done,
    output logic signed [lcar_pkg::DIV_W-1:0] quotient
);
    import lcar_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, q_reg[DIV_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            rem_next  = '0;
            q_next    = dividend;
            dvs_next  = divisor;
            neg_next  = neg;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            q_next   = {q_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

// File: hdl/lcar_engine.sv
// serial read engine, averaging state and result arithmetic
module lcar_engine #(
    parameter int DATA_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcar_pkg::ctrl_cmd_t               cmd,
    output lcar_pkg::eng_stat_t               stat,
    input  logic                              fast_speed,
    input  logic [31:0]                       scale,
    input  logic [2:0]                        operation,
    input  logic                              calibrate,
    input  logic [7:0]                        sample_count,
    input  logic                              dout,
    input  logic                              ms_tick,
    output logic                              step_sclk,
    output logic                              step_busy,
    output logic                              step_done,
    output logic [1:0]                        step_status,
    output logic [1:0]                        fin_status,
    output logic [31:0]                       fin_result,
    output logic                              div_neg,
    output logic [lcar_pkg::DIV_W-1:0]        div_dividend,
    output logic [lcar_pkg::DVS_W-1:0]        div_divisor,
    input  logic signed [lcar_pkg::DIV_W-1:0] div_quotient
);
    import lcar_pkg::*;

    localparam int CW = $clog2(DATA_BITS + 3);

    phase_t               phase_reg, phase_next;
    logic                 cal_reg, cal_next;
    logic [2:0]           op_reg, op_next;
    logic [CW-1:0]        bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [9:0]           ms_reg, ms_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           total_reg, total_next;
    logic [31:0]          sum_reg, sum_next;
    logic [31:0]          tare_reg, tare_next;
    logic signed [39:0]   avg_reg;

    logic        go_reads, go_start, start_cal, fin;
    logic [1:0]  st;
    logic [9:0]  ms_inc, target, limit;
    logic [CW-1:0] last_cnt;
    logic        want_high;
    logic signed [40:0] diff;
    logic signed [63:0] avg_div_in, units_div_in, sel_in;

    always_comb
    begin
        phase_next = phase_reg;
        cal_next   = cal_reg;
        op_next    = op_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        ms_next    = ms_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        sum_next   = sum_reg;
        go_reads   = 1'b0;
        go_start   = 1'b0;
        start_cal  = 1'b0;
        fin        = 1'b0;
        st         = ST_OK;
        step_sclk  = 1'b0;
        ms_inc     = ms_reg + 10'd1;
        limit      = fast_speed ? WAIT_LIMIT_FAST : WAIT_LIMIT_SLOW;
        target     = cal_reg ? (fast_speed ? CAL_DELAY_FAST : CAL_DELAY_SLOW) : READ_GAP;
        last_cnt   = cal_reg ? CW'(DATA_BITS + 2) : CW'(DATA_BITS + 1);
        want_high  = phase_reg == PH_WAIT_HIGH;

        unique case (phase_reg)
            PH_WAIT_HIGH, PH_WAIT_LOW:
            begin
                if (dout == want_high)
                begin
                    ms_next    = '0;
                    bit_next   = '0;
                    shift_next = '0;
                    phase_next = want_high ? PH_WAIT_LOW : PH_CLK_HIGH;
                end
                else if (ms_tick)
                begin
                    ms_next = ms_inc;
                    if (ms_inc > limit)
                    begin
                        // a calibration read that times out just moves on
                        if (cal_reg)
                            go_reads = 1'b1;
                        else
                        begin
                            fin = 1'b1;
                            st  = want_high ? ST_TO_HIGH : ST_TO_LOW;
                        end
                    end
                end
            end
            PH_CLK_HIGH:
            begin
                step_sclk  = 1'b1;
                phase_next = PH_CLK_LOW;
            end
            PH_CLK_LOW:
            begin
                if (bit_reg < CW'(DATA_BITS))
                    shift_next = {shift_reg[DATA_BITS-2:0], dout};
                bit_next = bit_reg + 1'b1;
                if (bit_next >= last_cnt)
                begin
                    ms_next = '0;
                    if (!cal_reg)
                    begin
                        sum_next = sum_reg
                                 + {{(32-DATA_BITS){shift_next[DATA_BITS-1]}}, shift_next};
                        if (rem_reg != 8'd0)
                            rem_next = rem_reg - 8'd1;
                    end
                    phase_next = PH_DELAY;
                end
                else
                    phase_next = PH_CLK_HIGH;
            end
            PH_DELAY:
            begin
                if (ms_tick)
                    ms_next = ms_inc;
                if (ms_next >= target)
                begin
                    if (cal_reg)
                        go_reads = 1'b1;
                    else if (rem_reg == 8'd0)
                        fin = 1'b1;
                    else
                        go_start = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (operation >= OP_RAW && operation <= OP_TARE)
                begin
                    op_next    = operation;
                    rem_next   = sample_count;
                    total_next = sample_count;
                    sum_next   = '0;
                    if (calibrate)
                    begin
                        go_start  = 1'b1;
                        start_cal = 1'b1;
                    end
                    else
                        go_reads = 1'b1;
                end
            end
        endcase

        if (go_reads)
        begin
            if (rem_next == 8'd0)
            begin
                fin = 1'b1;
                st  = ST_DIV0;
            end
            else
                go_start = 1'b1;
        end
        if (go_start)
        begin
            ms_next    = '0;
            bit_next   = '0;
            shift_next = '0;
            phase_next = PH_WAIT_HIGH;
            cal_next   = start_cal;
        end
        if (fin)
        begin
            phase_next = PH_IDLE;
            cal_next   = 1'b0;
            if (st == ST_OK && total_reg == 8'd0)
                st = ST_DIV0;
        end
    end

    assign step_busy   = phase_next != PH_IDLE;
    assign step_done   = fin;
    assign step_status = st;

    assign stat.fin_ok     = fin && st == ST_OK;
    assign stat.op_units   = op_reg == OP_UNITS;
    assign stat.scale_zero = scale == 32'd0;

    // divider operands: sum*256 over the count, or diff*65536 over the scale
    assign diff         = $signed({avg_reg[39], avg_reg})
                        - $signed({{9{tare_reg[31]}}, tare_reg});
    assign avg_div_in   = $signed({{24{sum_reg[31]}}, sum_reg, 8'h00});
    assign units_div_in = $signed({{7{diff[40]}}, diff, 16'h0000});
    assign sel_in       = cmd.sel_units ? units_div_in : avg_div_in;
    assign div_neg      = sel_in[63];
    assign div_dividend = sel_in[63] ? DIV_W'(-sel_in) : DIV_W'(sel_in);
    assign div_divisor  = cmd.sel_units ? scale : {24'h0, total_reg};

    always_comb
    begin
        fin_status = ST_OK;
        fin_result = '0;
        case (op_reg)
            OP_RAW:   fin_result = avg_reg[31:0];
            OP_VALUE: fin_result = sat32(64'(diff));
            OP_UNITS:
            begin
                if (scale == 32'd0)
                    fin_status = ST_DIV0;
                else
                    fin_result = sat32(div_quotient);
            end
            OP_TARE:  fin_result = avg_reg[31:0];
            default:  fin_result = '0;
        endcase
    end

    always_comb
    begin
        tare_next = tare_reg;
        if (cmd.fin_load && op_reg == OP_TARE)
            tare_next = avg_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cal_reg   <= 1'b0;
            op_reg    <= OP_NONE;
            bit_reg   <= '0;
            shift_reg <= '0;
            ms_reg    <= '0;
            rem_reg   <= '0;
            total_reg <= '0;
            sum_reg   <= '0;
            tare_reg  <= '0;
        end
        else
        begin
            if (cmd.step_en)
            begin
                phase_reg <= phase_next;
                cal_reg   <= cal_next;
                op_reg    <= op_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                ms_reg    <= ms_next;
                rem_reg   <= rem_next;
                total_reg <= total_next;
                sum_reg   <= sum_next;
            end
            tare_reg <= tare_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.avg_load)
            avg_reg <= div_quotient[39:0];
    end
endmodule

// File: hdl/lcar_ctrl.sv
// sequencing controller: step acceptance, divide passes, result hand-off
module lcar_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  logic                div_done,
    input  lcar_pkg::eng_stat_t stat,
    output lcar_pkg::ctrl_cmd_t cmd
);
    import lcar_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        accept;

    assign accept = state_reg == C_RUN && in_valid && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_RUN:         if (accept && stat.fin_ok) state_next = C_AVG_START;
            C_AVG_START:   state_next = C_AVG_WAIT;
            C_AVG_WAIT:
            begin
                if (div_done)
                    state_next = (stat.op_units && !stat.scale_zero) ? C_UNITS_START : C_OUT;
            end
            C_UNITS_START: state_next = C_UNITS_WAIT;
            C_UNITS_WAIT:  if (div_done) state_next = C_OUT;
            C_OUT:         if (out_free) state_next = C_RUN;
            default:       state_next = C_RUN;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            C_RUN:
            begin
                cmd.in_ready      = out_free;
                cmd.step_en       = accept;
                cmd.out_load_step = accept && !stat.fin_ok;
            end
            C_AVG_START:   cmd.div_start = 1'b1;
            C_AVG_WAIT:    cmd.avg_load  = div_done;
            C_UNITS_START:
            begin
                cmd.div_start = 1'b1;
                cmd.sel_units = 1'b1;
            end
            C_UNITS_WAIT:  cmd.sel_units = 1'b1;
            C_OUT:         cmd.fin_load  = out_free;
            default:       cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_RUN;
        else
            state_reg <= state_next;
    end
endmodule

// File: hdl/load_cell_adc_reader.sv
// load cell converter reader: one step word in, one result word out
// a step word is taken in the run state while the output register is free
// a step that completes a command with data runs a divide pass for the average,
// plus one for units if the scale is nonzero, before its result word is loaded
// reset (rst_n low) clears the engine to idle, zero tare, fast_speed 0 and scale 1.0
module load_cell_adc_reader #(
    parameter int DATA_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lcar_in_if.sink     step_in,
    lcar_out_if.source  step_out
);
    import lcar_pkg::*;

    logic        fast_reg;
    logic [31:0] scale_reg;

    ctrl_cmd_t   cmd;
    eng_stat_t   stat;
    logic        out_free;
    logic        div_done, div_neg;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic signed [DIV_W-1:0] div_quotient;

    logic        step_sclk, step_busy, step_done;
    logic [1:0]  step_status, fin_status;
    logic [31:0] fin_result;

    logic        ov_reg, ov_next;
    logic        sclk_reg, busy_reg, done_reg;
    logic [1:0]  status_reg;
    logic [31:0] result_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg  <= 1'b0;
            scale_reg <= 32'h0001_0000;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_FAST:  fast_reg  <= pwdata[0];
                REG_SCALE: scale_reg <= pwdata;
                default:   fast_reg  <= fast_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_SCALE) ? scale_reg : {31'h0, fast_reg};

    assign out_free = !ov_reg || step_out.ready;

    lcar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step_in.valid),
        .out_free (out_free),
        .div_done (div_done),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcar_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .fast_speed   (fast_reg),
        .scale        (scale_reg),
        .operation    (step_in.operation),
        .calibrate    (step_in.calibrate),
        .sample_count (step_in.sample_count),
        .dout         (step_in.dout),
        .ms_tick      (step_in.ms_tick),
        .step_sclk    (step_sclk),
        .step_busy    (step_busy),
        .step_done    (step_done),
        .step_status  (step_status),
        .fin_status   (fin_status),
        .fin_result   (fin_result),
        .div_neg      (div_neg),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quotient (div_quotient)
    );

    lcar_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .neg      (div_neg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign step_in.ready = cmd.in_ready;

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load_step || cmd.fin_load)
            ov_next = 1'b1;
        else if (step_out.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    // output word: plain step result, or the finished arithmetic result
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_step)
        begin
            sclk_reg   <= step_sclk;
            busy_reg   <= step_busy;
            done_reg   <= step_done;
            status_reg <= step_status;
            result_reg <= '0;
        end
        else if (cmd.fin_load)
        begin
            sclk_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b1;
            status_reg <= fin_status;
            result_reg <= (fin_status == ST_OK) ? fin_result : 32'h0;
        end
    end

    assign step_out.valid    = ov_reg;
    assign step_out.sclk     = sclk_reg;
    assign step_out.busy_res = busy_reg;
    assign step_out.done_res = done_reg;
    assign step_out.status   = status_reg;
    assign step_out.result   = result_reg;
endmodule

// File: hdl/lcar_checker.sv
// port-level checks for the load cell reader, bound to the top level
`include "load_cell_adc_reader_assert.svh"

module lcar_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        sclk,
    input logic        busy_res,
    input logic        done_res,
    input logic [1:0]  status,
    input logic [31:0] result
);
    import lcar_pkg::*;

    `LCAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result))
    `LCAR_ASSERT_IMPL(a_done_idle, out_valid && done_res, !busy_res && !sclk)
    `LCAR_ASSERT_IMPL(a_quiet_word, out_valid && !done_res, status == ST_OK && result == 32'd0)
    `LCAR_ASSERT_IMPL(a_err_zero, out_valid && done_res && status != ST_OK, result == 32'd0)
endmodule

bind load_cell_adc_reader lcar_checker u_lcar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (step_out.valid),
    .out_ready (step_out.ready),
    .sclk      (step_out.sclk),
    .busy_res  (step_out.busy_res),
    .done_res  (step_out.done_res),
    .status    (step_out.status),
    .result    (step_out.result)
);

// File: test/testbench.sv
// self-checking testbench for the load cell converter reader
`timescale 1ns / 1ps

module testbench;
    import lcar_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_STEPS   = 650;

    typedef struct {
        logic [2:0] operation;
        logic       calibrate;
        logic [7:0] sample_count;
        logic       dout;
        logic       ms_tick;
    } step_word_t;

    typedef struct {
        logic        sclk;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] result;
    } step_result_t;

    // mirrors the reader engine and keeps the words it should produce
    class reader_scoreboard;
        logic        fast_speed;
        logic [31:0] scale;
        phase_t      ph;
        logic        cal_flag;
        logic [2:0]  pend_op;
        logic [4:0]  bits;
        logic [23:0] shift;
        logic [9:0]  ms;
        logic [7:0]  remaining;
        logic [7:0]  total;
        logic [31:0] sum;
        logic [31:0] tare;
        step_result_t cur;
        step_result_t expected[$];
        int steps, errors, done_count, err_count;

        function new();
            fast_speed = 1'b0; scale = 32'd65536;
            ph = PH_IDLE; cal_flag = 1'b0; pend_op = OP_NONE; bits = '0; shift = '0;
            ms = '0; remaining = '0; total = '0; sum = '0; tare = '0;
            steps = 0; errors = 0; done_count = 0; err_count = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void close_cmd(logic [1:0] st);
            longint avg, diff, res;
            res = 0;
            ph = PH_IDLE;
            cal_flag = 1'b0;
            cur.done_res = 1'b1;
            if (st == ST_OK && total == 0)
                st = ST_DIV0;
            if (st == ST_OK)
            begin
                avg = longint'($signed(sum)) * 256 / longint'(total);
                diff = avg - longint'($signed(tare));
                case (pend_op)
                    OP_RAW: res = avg;
                    OP_VALUE: res = clamp32(diff);
                    OP_UNITS:
                        if (scale == 0)
                            st = ST_DIV0;
                        else
                            res = clamp32(diff * 65536 / longint'(scale));
                    OP_TARE:
                    begin
                        tare = avg[31:0];
                        res = avg;
                    end
                    default: ;
                endcase
            end
            cur.status = st;
            cur.result = (st == ST_OK) ? res[31:0] : 32'd0;
        endfunction

        function void open_read(logic c);
            ms = '0; bits = '0; shift = '0;
            cal_flag = c;
            ph = PH_WAIT_HIGH;
        endfunction

        function void first_read();
            if (remaining == 0)
                close_cmd(ST_DIV0);
            else
                open_read(1'b0);
        endfunction

        function void note_step(step_word_t w);
            logic [9:0] lim, tgt;
            logic       want;
            int         extra;
            cur = '{default: '0};
            lim = fast_speed ? WAIT_LIMIT_FAST : WAIT_LIMIT_SLOW;
            extra = cal_flag ? 2 : 1;
            steps++;
            case (ph)
                PH_WAIT_HIGH, PH_WAIT_LOW:
                begin
                    want = (ph == PH_WAIT_HIGH);
                    if (w.dout == want)
                    begin
                        ms = '0; bits = '0; shift = '0;
                        ph = want ? PH_WAIT_LOW : PH_CLK_HIGH;
                    end
                    else if (w.ms_tick)
                    begin
                        ms = ms + 10'd1;
                        if (ms > lim)
                        begin
                            if (cal_flag)
                                first_read();
                            else
                                close_cmd(want ? ST_TO_HIGH : ST_TO_LOW);
                        end
                    end
                end
                PH_CLK_HIGH:
                begin
                    cur.sclk = 1'b1;
                    ph = PH_CLK_LOW;
                end
                PH_CLK_LOW:
                begin
                    if (bits < 24)
                        shift = {shift[22:0], w.dout};
                    bits = bits + 5'd1;
                    if (bits >= 24 + extra)
                    begin
                        ms = '0;
                        if (!cal_flag)
                        begin
                            sum = sum + {{8{shift[23]}}, shift};
                            if (remaining > 0)
                                remaining--;
                        end
                        ph = PH_DELAY;
                    end
                    else
                        ph = PH_CLK_HIGH;
                end
                PH_DELAY:
                begin
                    tgt = cal_flag ? (fast_speed ? CAL_DELAY_FAST : CAL_DELAY_SLOW) : READ_GAP;
                    if (w.ms_tick)
                        ms = ms + 10'd1;
                    if (ms >= tgt)
                    begin
                        if (cal_flag)
                            first_read();
                        else if (remaining == 0)
                            close_cmd(ST_OK);
                        else
                            open_read(1'b0);
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                    if (w.operation >= OP_RAW && w.operation <= OP_TARE)
                    begin
                        pend_op = w.operation;
                        remaining = w.sample_count;
                        total = w.sample_count;
                        sum = '0;
                        if (w.calibrate)
                            open_read(1'b1);
                        else
                            first_read();
                    end
                end
            endcase
            cur.busy_res = (ph != PH_IDLE);
            expected.push_back(cur);
        endfunction

        function void check_result(step_result_t act);
            step_result_t e;
            if (expected.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected.pop_front();
            if (act.sclk !== e.sclk)
            begin
                $error("sclk: expected %0d, actual %0d", e.sclk, act.sclk);
                errors++;
            end
            if (act.busy_res !== e.busy_res)
            begin
                $error("busy_res: expected %0d, actual %0d", e.busy_res, act.busy_res);
                errors++;
            end
            if (act.done_res !== e.done_res)
            begin
                $error("done_res: expected %0d, actual %0d", e.done_res, act.done_res);
                errors++;
            end
            if (act.status !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, act.status);
                errors++;
            end
            if (act.result !== e.result)
            begin
                $error("result: expected %0h, actual %0h", e.result, act.result);
                errors++;
            end
            if (e.done_res)
            begin
                done_count++;
                if (e.status != ST_OK)
                    err_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lcar_in_if  step_ch();
    lcar_out_if res_ch();

    reader_scoreboard sb;
    bit idle_on;
    bit hold_req;
    int quiet_cycles;

    load_cell_adc_reader dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .step_in(step_ch), .step_out(res_ch)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    task automatic push_step(step_word_t w);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            step_ch.valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        step_ch.valid        <= 1;
        step_ch.operation    <= w.operation;
        step_ch.calibrate    <= w.calibrate;
        step_ch.sample_count <= w.sample_count;
        step_ch.dout         <= w.dout;
        step_ch.ms_tick      <= w.ms_tick;
        do @(posedge clk); while (!step_ch.ready);
        sb.note_step(w);
    endtask

    task automatic drain();
        step_ch.valid <= 0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        drain();
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_FAST)
            sb.fast_speed = val[0];
        else
            sb.scale = val;
    endtask

    function automatic logic [23:0] pick_word(int mode);
        case (mode)
            1: return 24'h7fffff;
            2: return 24'h800000;
            3: return 24'hffffff;
            4: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    // one command, then converter-like pin activity until the reader goes idle
    // tmo: 1 stall the high wait, 2 stall the low wait, 3 stall the calibration wait
    task automatic run_cmd(logic [2:0] op, bit cal, logic [7:0] cnt, int tmo, int mode);
        step_word_t  w;
        logic [23:0] word;
        bit          stall;
        word = 0;
        w.operation = op; w.calibrate = cal; w.sample_count = cnt;
        w.dout = 1'($urandom_range(0, 1)); w.ms_tick = 1'($urandom_range(0, 1));
        push_step(w);
        while (sb.ph != PH_IDLE)
        begin
            w.operation = 3'($urandom_range(0, 7));
            w.calibrate = 1'($urandom_range(0, 1));
            w.sample_count = 8'($urandom);
            w.ms_tick = 1'($urandom_range(0, 1));
            w.dout = 1'($urandom_range(0, 1));
            stall = 0;
            case (sb.ph)
                PH_WAIT_HIGH:
                begin
                    stall = (tmo == 1 && !sb.cal_flag) || (tmo == 3 && sb.cal_flag);
                    w.dout = stall ? 1'b0 : ($urandom_range(0, 2) == 0);
                end
                PH_WAIT_LOW:
                begin
                    stall = (tmo == 2 && !sb.cal_flag);
                    w.dout = stall ? 1'b1 : ($urandom_range(0, 2) != 0);
                end
                PH_CLK_LOW:
                begin
                    if (sb.bits == 0)
                        word = pick_word(mode);
                    if (sb.bits < 24)
                        w.dout = word[23 - sb.bits];
                end
                PH_DELAY:
                    if (sb.cal_flag)
                        w.ms_tick = 1;
                default: ;
            endcase
            if (stall)
                w.ms_tick = 1;
            else if ($urandom_range(0, 31) == 0)
                w.dout = ~w.dout;
            push_step(w);
        end
    endtask

    task automatic idle_step(logic [2:0] op);
        step_word_t w;
        w.operation = op; w.calibrate = 1'($urandom_range(0, 1));
        w.sample_count = 8'($urandom); w.dout = 1'($urandom_range(0, 1));
        w.ms_tick = 1'($urandom_range(0, 1));
        push_step(w);
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        res_ch.ready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 0;
                repeat (3000) @(posedge clk);
                hold_req = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        step_result_t act;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                act.sclk = res_ch.sclk;
                act.busy_res = res_ch.busy_res;
                act.done_res = res_ch.done_res;
                act.status = res_ch.status;
                act.result = res_ch.result;
                sb.check_result(act);
            end
            if ((res_ch.valid && res_ch.ready) || (step_ch.valid && step_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int goal, ncmd;
        bit paused;
        logic [31:0] sc;
        sb = new();
        idle_on = 1; hold_req = 0; quiet_cycles = 0; paused = 0; ncmd = 0;
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        step_ch.valid = 0; step_ch.operation = OP_NONE; step_ch.calibrate = 0;
        step_ch.sample_count = 0; step_ch.dout = 0; step_ch.ms_tick = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every operation, data extremes, ignored codes, error paths
        run_cmd(OP_RAW, 0, 8'd1, 0, 0);
        run_cmd(OP_VALUE, 0, 8'd2, 0, 1);
        run_cmd(OP_TARE, 0, 8'd1, 0, 2);
        run_cmd(OP_VALUE, 0, 8'd1, 0, 1);
        run_cmd(OP_UNITS, 0, 8'd1, 0, 3);
        idle_step(OP_NONE);
        idle_step(3'd5);
        idle_step(3'd6);
        idle_step(3'd7);
        run_cmd(OP_RAW, 0, 8'd0, 0, 0);
        reg_write(REG_FAST, 32'd1);
        run_cmd(OP_TARE, 1, 8'd0, 0, 0);
        run_cmd(OP_RAW, 1, 8'd1, 0, 4);
        reg_write(REG_SCALE, 32'd0);
        run_cmd(OP_UNITS, 0, 8'd1, 0, 0);
        reg_write(REG_SCALE, 32'd1);
        run_cmd(OP_UNITS, 0, 8'd1, 0, 1);
        reg_write(REG_SCALE, 32'hffff_ffff);
        run_cmd(OP_UNITS, 0, 8'd2, 0, 0);
        run_cmd(OP_RAW, 0, 8'd1, 1, 0);
        run_cmd(OP_RAW, 0, 8'd1, 2, 0);
        run_cmd(OP_VALUE, 1, 8'd1, 3, 0);
        run_cmd(OP_RAW, 0, 8'd3, 0, 0);
        reg_write(REG_FAST, 32'd0);
        reg_write(REG_SCALE, 32'd65536);
        run_cmd(OP_VALUE, 1, 8'd1, 0, 0);

        // random commands with varying settings
        goal = sb.steps + RANDOM_STEPS;
        hold_req = 1;
        while (sb.steps < goal)
        begin
            if (ncmd % 6 == 5)
            begin
                reg_write(REG_FAST, $urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0: sc = 32'd0;
                    1: sc = 32'd1;
                    2: sc = 32'hffff_ffff;
                    3: sc = 32'd65536;
                    4: sc = $urandom_range(1, 4096);
                    default: sc = $urandom;
                endcase
                reg_write(REG_SCALE, sc);
            end
            if (!paused && sb.steps > goal - RANDOM_STEPS / 2)
            begin
                drain();
                paused = 1;
            end
            if (sb.steps > goal - 120)
                idle_on = 0;
            run_cmd(3'($urandom_range(OP_RAW, OP_TARE)),
                    sb.fast_speed ? ($urandom_range(0, 5) == 0) : ($urandom_range(0, 30) == 0),
                    ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                    ($urandom_range(0, 40) == 0) ? $urandom_range(1, 3) : 0,
                    $urandom_range(0, 7));
            ncmd++;
        end

        step_ch.valid <= 0;
        while (sb.expected.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d steps, %0d finished commands (%0d with error status)",
                 sb.steps, sb.done_count, sb.err_count);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lcar_pkg.sv
hdl/lcar_if.sv
hdl/lcar_div.sv
hdl/lcar_engine.sv
hdl/lcar_ctrl.sv
hdl/load_cell_adc_reader.sv
hdl/lcar_checker.sv
test/testbench.sv
